[src/bibchk_pkg.sv]
package bibchk_pkg;

  // Token kinds as they arrive from the tokenizer; also the plain tags.
  localparam logic [3:0] K_ENTRY = 4'd0;
  localparam logic [3:0] K_TEXT  = 4'd1;
  localparam logic [3:0] K_OPEN  = 4'd2;
  localparam logic [3:0] K_CLOSE = 4'd3;
  localparam logic [3:0] K_EQUAL = 4'd4;
  localparam logic [3:0] K_COMMA = 4'd5;
  localparam logic [3:0] K_QUOTE = 4'd6;
  localparam logic [3:0] K_EOF   = 4'd7;
  localparam logic [3:0] K_OTHER = 4'd8;

  // Retagged text tokens.
  localparam logic [3:0] T_TYPE  = 4'd9;
  localparam logic [3:0] T_IDENT = 4'd10;
  localparam logic [3:0] T_KEY   = 4'd11;
  localparam logic [3:0] T_VALUE = 4'd12;

  // Check status codes.
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_WRONG  = 2'd1;
  localparam logic [1:0] ST_NUMBER = 2'd2;
  localparam logic [1:0] ST_SKIP   = 2'd3;

  typedef enum logic [4:0] {
    PH_ENTRY     = 5'd0,
    PH_TYPE      = 5'd1,
    PH_S_OPEN    = 5'd2,
    PH_S_KEY     = 5'd3,
    PH_S_EQ      = 5'd4,
    PH_S_VAL     = 5'd5,
    PH_S_CLOSE1  = 5'd6,
    PH_S_CLOSE2  = 5'd7,
    PH_OPEN      = 5'd8,
    PH_IDENT     = 5'd9,
    PH_COMMA     = 5'd10,
    PH_KEY_FIRST = 5'd11,
    PH_KEY_LOOP  = 5'd12,
    PH_EQ        = 5'd13,
    PH_VAL       = 5'd14,
    PH_AFTER_NUM = 5'd15,
    PH_VTEXT     = 5'd16,
    PH_VCLOSE    = 5'd17,
    PH_SEP       = 5'd18,
    PH_DONE      = 5'd19,
    PH_ERROR     = 5'd20
  } phase_e;

endpackage

[src/bibchk_if.sv]
interface bibchk_tok_if;
  logic       valid;
  logic       ready;
  logic [3:0] token_kind;
  logic       text_is_number;
  logic       text_is_string_keyword;
  logic       last_token;

  modport source (
    output valid, token_kind, text_is_number, text_is_string_keyword, last_token,
    input  ready
  );
  modport sink (
    input  valid, token_kind, text_is_number, text_is_string_keyword, last_token,
    output ready
  );
endinterface

interface bibchk_res_if;
  logic       valid;
  logic       ready;
  logic [3:0] out_tag;
  logic [1:0] check_status;
  logic [3:0] expected_kind;
  logic       is_last;

  modport source (
    output valid, out_tag, check_status, expected_kind, is_last,
    input  ready
  );
  modport sink (
    input  valid, out_tag, check_status, expected_kind, is_last,
    output ready
  );
endinterface

[src/bibtex_entry_token_checker_core.sv]
// Bibliography entry token checker.
// tok_i carries one token beat of an entry: its kind, two text flags from the
// tokenizer (parses as a number, equals the string keyword) and a last-token
// mark. res_o returns one beat per token: the final tag (text tokens retagged
// as type, identifier, key or value), a check status, the expected kind on a
// wrong-kind error, and is_last echoed so the receiver can close the entry.
// A token is registered on acceptance, checked against the grammar phase and
// lands in the result register as soon as that register is free. One token
// per cycle is sustained while res_o is ready; the only loop is the grammar
// phase register, updated once per token by a small next-state decode.
// After an error every further token of the entry reports "not checked"
// until the last token, which returns the phase to the entry marker.
// Reset clears both valid bits and puts the phase at "expect entry marker".
// When res_o stalls, the result register holds and the input register still
// takes one more token; tok_i.ready drops only when both stages are full.
module bibtex_entry_token_checker_core
  import bibchk_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  bibchk_tok_if.sink    tok_i,
  bibchk_res_if.source  res_o
);

  // Input stage
  logic       in_valid_q;
  logic [3:0] in_kind_q;
  logic       in_num_q;
  logic       in_kw_q;
  logic       in_last_q;

  // Result stage
  logic       out_valid_q;
  logic [3:0] out_tag_q,    out_tag_d;
  logic [1:0] out_status_q, out_status_d;
  logic [3:0] out_expect_q, out_expect_d;
  logic       out_last_q;

  phase_e     phase_q, phase_d, phase_chk;
  logic [3:0] kind;
  logic       out_free;
  logic       advance;
  logic       accept;

  // Handshake: the input stage drains whenever the result register is free.
  assign out_free    = !out_valid_q || res_o.ready;
  assign advance     = in_valid_q && out_free;
  assign tok_i.ready = !in_valid_q || out_free;
  assign accept      = tok_i.valid && tok_i.ready;

  // Fold kinds beyond the defined range onto "other".
  assign kind = (in_kind_q > K_OTHER) ? K_OTHER : in_kind_q;

  // Next grammar phase, before the end-of-entry override.
  always_comb begin
    unique case (phase_q)
      PH_ENTRY:     phase_chk = (kind == K_ENTRY) ? PH_TYPE : PH_ERROR;
      PH_TYPE: begin
        if (kind == K_TEXT) phase_chk = in_kw_q ? PH_S_OPEN : PH_OPEN;
        else                phase_chk = PH_ERROR;
      end
      PH_S_OPEN:    phase_chk = (kind == K_OPEN)  ? PH_S_KEY    : PH_ERROR;
      PH_S_KEY:     phase_chk = (kind == K_TEXT)  ? PH_S_EQ     : PH_ERROR;
      PH_S_EQ:      phase_chk = (kind == K_EQUAL) ? PH_S_VAL    : PH_ERROR;
      PH_S_VAL:     phase_chk = (kind == K_TEXT)  ? PH_S_CLOSE1 : PH_ERROR;
      PH_S_CLOSE1:  phase_chk = (kind == K_CLOSE) ? PH_S_CLOSE2 : PH_ERROR;
      PH_S_CLOSE2:  phase_chk = (kind == K_CLOSE) ? PH_DONE     : PH_ERROR;
      PH_OPEN:      phase_chk = (kind == K_OPEN)  ? PH_IDENT    : PH_ERROR;
      PH_IDENT:     phase_chk = (kind == K_TEXT)  ? PH_COMMA    : PH_ERROR;
      PH_COMMA:     phase_chk = (kind == K_COMMA) ? PH_KEY_FIRST : PH_ERROR;
      PH_KEY_FIRST: phase_chk = (kind == K_TEXT)  ? PH_EQ       : PH_ERROR;
      PH_KEY_LOOP: begin
        priority if (kind == K_EOF)  phase_chk = PH_DONE;
        else if (kind == K_TEXT)     phase_chk = PH_EQ;
        else                         phase_chk = PH_ERROR;
      end
      PH_EQ:        phase_chk = (kind == K_EQUAL) ? PH_VAL : PH_ERROR;
      PH_VAL: begin
        priority if (kind == K_TEXT)             phase_chk = in_num_q ? PH_AFTER_NUM
                                                                      : PH_ERROR;
        else if (kind == K_OPEN || kind == K_QUOTE)  phase_chk = PH_VTEXT;
        else if (kind == K_COMMA || kind == K_CLOSE) phase_chk = PH_KEY_LOOP;
        else                                         phase_chk = PH_ERROR;
      end
      PH_AFTER_NUM: begin
        priority if (kind == K_OPEN || kind == K_QUOTE) phase_chk = PH_VTEXT;
        else if (kind == K_COMMA || kind == K_CLOSE)    phase_chk = PH_KEY_LOOP;
        else                                            phase_chk = PH_ERROR;
      end
      PH_VTEXT:     phase_chk = (kind == K_TEXT) ? PH_VCLOSE : PH_ERROR;
      PH_VCLOSE:    phase_chk = (kind == K_CLOSE || kind == K_QUOTE) ? PH_SEP : PH_ERROR;
      PH_SEP:       phase_chk = (kind == K_COMMA || kind == K_CLOSE) ? PH_KEY_LOOP
                                                                     : PH_ERROR;
      // Finished, failed and unused phases hold until the entry ends.
      default:      phase_chk = phase_q;
    endcase
  end

  // The last token of an entry always rearms for the next entry marker.
  always_comb begin
    phase_d = phase_q;
    if (advance) phase_d = in_last_q ? PH_ENTRY : phase_chk;
  end

  // Result beat for the token in the input stage.
  always_comb begin
    out_tag_d    = kind;
    out_status_d = ST_OK;
    out_expect_d = K_ENTRY;
    unique case (phase_q)
      PH_ENTRY, PH_S_OPEN, PH_OPEN: begin
        if (phase_chk == PH_ERROR) begin
          out_status_d = ST_WRONG;
          out_expect_d = (phase_q == PH_ENTRY) ? K_ENTRY : K_OPEN;
        end
      end
      PH_S_EQ, PH_EQ: begin
        if (phase_chk == PH_ERROR) begin
          out_status_d = ST_WRONG;
          out_expect_d = K_EQUAL;
        end
      end
      PH_S_CLOSE1, PH_S_CLOSE2, PH_VCLOSE: begin
        if (phase_chk == PH_ERROR) begin
          out_status_d = ST_WRONG;
          out_expect_d = K_CLOSE;
        end
      end
      PH_COMMA, PH_AFTER_NUM, PH_SEP: begin
        if (phase_chk == PH_ERROR) begin
          out_status_d = ST_WRONG;
          out_expect_d = K_COMMA;
        end
      end
      PH_TYPE, PH_S_KEY, PH_S_VAL, PH_IDENT, PH_KEY_FIRST, PH_VTEXT: begin
        if (kind == K_TEXT) begin
          unique case (phase_q)
            PH_TYPE:             out_tag_d = T_TYPE;
            PH_IDENT:            out_tag_d = T_IDENT;
            PH_S_KEY, PH_KEY_FIRST: out_tag_d = T_KEY;
            default:             out_tag_d = T_VALUE;
          endcase
        end else begin
          out_status_d = ST_WRONG;
          out_expect_d = K_TEXT;
        end
      end
      PH_KEY_LOOP: begin
        priority if (kind == K_EOF) begin
          out_status_d = ST_SKIP;
        end else if (kind == K_TEXT) begin
          out_tag_d = T_KEY;
        end else begin
          out_status_d = ST_WRONG;
          out_expect_d = K_TEXT;
        end
      end
      PH_VAL: begin
        priority if (kind == K_TEXT) begin
          // Number text keeps its plain tag; anything else wants a number.
          if (!in_num_q) out_status_d = ST_NUMBER;
        end else if (phase_chk == PH_ERROR) begin
          out_status_d = ST_WRONG;
          out_expect_d = K_COMMA;
        end
      end
      default: out_status_d = ST_SKIP;
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      phase_q     <= PH_ENTRY;
    end else begin
      if (tok_i.ready) in_valid_q <= tok_i.valid;
      if (out_free)    out_valid_q <= in_valid_q;
      phase_q <= phase_d;
    end
  end

  // Payload registers: capture on accept, advance when the result slot frees.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_kind_q <= tok_i.token_kind;
      in_num_q  <= tok_i.text_is_number;
      in_kw_q   <= tok_i.text_is_string_keyword;
      in_last_q <= tok_i.last_token;
    end
    if (advance) begin
      out_tag_q    <= out_tag_d;
      out_status_q <= out_status_d;
      out_expect_q <= out_expect_d;
      out_last_q   <= in_last_q;
    end
  end

  assign res_o.valid         = out_valid_q;
  assign res_o.out_tag       = out_tag_q;
  assign res_o.check_status  = out_status_q;
  assign res_o.expected_kind = out_expect_q;
  assign res_o.is_last       = out_last_q;

  // The last token of an entry rearms the grammar.
  a_last_rearms: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && in_last_q |=> phase_q == PH_ENTRY)
    else $error("phase not rearmed after last token");

  // An error sticks until the entry ends.
  a_error_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_ERROR && !(advance && in_last_q) |=> phase_q == PH_ERROR)
    else $error("error phase left before end of entry");

  // An expected kind is reported only with a wrong-kind status.
  a_expect_only_wrong: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_status_q != ST_WRONG |-> out_expect_q == K_ENTRY)
    else $error("expected kind set without wrong-kind status");

  // A missing number is only ever reported on a plain text token.
  a_number_on_text: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_status_q == ST_NUMBER |-> out_tag_q == K_TEXT)
    else $error("number status on a non-text token");

endmodule

[dv/bibchk_scoreboard.sv]
module bibchk_scoreboard
  import bibchk_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  bibchk_tok_if       tok_i,
  bibchk_res_if       res_i,
  output int unsigned err_cnt_o,
  output int unsigned pending_o,
  output int unsigned checked_o,
  output int unsigned flagged_o
);

  typedef struct packed {
    logic [3:0] tag;
    logic [1:0] status;
    logic [3:0] exp_kind;
    logic       last;
  } verdict_t;

  verdict_t    verdict_q[$];
  phase_e      phase_q;
  int unsigned n_err  = 0;
  int unsigned n_pend = 0;
  int unsigned n_chk  = 0;
  int unsigned n_flag = 0;

  assign err_cnt_o = n_err;
  assign pending_o = n_pend;
  assign checked_o = n_chk;
  assign flagged_o = n_flag;

  function automatic void want_one(input logic [3:0] kind, input logic [3:0] want,
                                   input logic [3:0] ok_tag, input phase_e nxt,
                                   inout verdict_t v);
    if (kind == want) begin
      v.tag   = ok_tag;
      phase_q = nxt;
    end else begin
      v.status   = ST_WRONG;
      v.exp_kind = want;
      phase_q    = PH_ERROR;
    end
  endfunction

  // First of the two kinds is the one reported on a miss.
  function automatic void want_two(input logic [3:0] kind, input logic [3:0] a,
                                   input logic [3:0] b, input phase_e nxt,
                                   inout verdict_t v);
    if (kind == a || kind == b) begin
      phase_q = nxt;
    end else begin
      v.status   = ST_WRONG;
      v.exp_kind = a;
      phase_q    = PH_ERROR;
    end
  endfunction

  function automatic verdict_t grade_token(input logic [3:0] kind_raw, input logic num,
                                           input logic kw, input logic last);
    verdict_t   v;
    logic [3:0] kind;
    kind       = (kind_raw > K_OTHER) ? K_OTHER : kind_raw;
    v.tag      = kind;
    v.status   = ST_OK;
    v.exp_kind = '0;
    v.last     = last;
    case (phase_q)
      PH_ENTRY:     want_one(kind, K_ENTRY, kind, PH_TYPE, v);
      PH_TYPE:      want_one(kind, K_TEXT, T_TYPE, kw ? PH_S_OPEN : PH_OPEN, v);
      PH_S_OPEN:    want_one(kind, K_OPEN, kind, PH_S_KEY, v);
      PH_S_KEY:     want_one(kind, K_TEXT, T_KEY, PH_S_EQ, v);
      PH_S_EQ:      want_one(kind, K_EQUAL, kind, PH_S_VAL, v);
      PH_S_VAL:     want_one(kind, K_TEXT, T_VALUE, PH_S_CLOSE1, v);
      PH_S_CLOSE1:  want_one(kind, K_CLOSE, kind, PH_S_CLOSE2, v);
      PH_S_CLOSE2:  want_one(kind, K_CLOSE, kind, PH_DONE, v);
      PH_OPEN:      want_one(kind, K_OPEN, kind, PH_IDENT, v);
      PH_IDENT:     want_one(kind, K_TEXT, T_IDENT, PH_COMMA, v);
      PH_COMMA:     want_one(kind, K_COMMA, kind, PH_KEY_FIRST, v);
      PH_KEY_FIRST: want_one(kind, K_TEXT, T_KEY, PH_EQ, v);
      PH_KEY_LOOP: begin
        if (kind == K_EOF) begin
          v.status = ST_SKIP;
          phase_q  = PH_DONE;
        end else begin
          want_one(kind, K_TEXT, T_KEY, PH_EQ, v);
        end
      end
      PH_EQ:        want_one(kind, K_EQUAL, kind, PH_VAL, v);
      PH_VAL: begin
        if (kind == K_TEXT) begin
          if (num) begin
            phase_q = PH_AFTER_NUM;
          end else begin
            v.status = ST_NUMBER;
            phase_q  = PH_ERROR;
          end
        end else if (kind == K_OPEN || kind == K_QUOTE) begin
          phase_q = PH_VTEXT;
        end else begin
          want_two(kind, K_COMMA, K_CLOSE, PH_KEY_LOOP, v);
        end
      end
      PH_AFTER_NUM: begin
        if (kind == K_OPEN || kind == K_QUOTE) begin
          phase_q = PH_VTEXT;
        end else begin
          want_two(kind, K_COMMA, K_CLOSE, PH_KEY_LOOP, v);
        end
      end
      PH_VTEXT:     want_one(kind, K_TEXT, T_VALUE, PH_VCLOSE, v);
      PH_VCLOSE:    want_two(kind, K_CLOSE, K_QUOTE, PH_SEP, v);
      PH_SEP:       want_two(kind, K_COMMA, K_CLOSE, PH_KEY_LOOP, v);
      default:      v.status = ST_SKIP;
    endcase
    if (last) phase_q = PH_ENTRY;
    return v;
  endfunction

  task automatic note_miss(input string what, input verdict_t want, input verdict_t got);
    n_err++;
    if (n_err <= 10) begin
      $display("%0t %s: exp tag=%0d st=%0d kind=%0d last=%0d  got tag=%0d st=%0d kind=%0d last=%0d",
               $realtime, what, want.tag, want.status, want.exp_kind, want.last,
               got.tag, got.status, got.exp_kind, got.last);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    verdict_t want;
    verdict_t got;
    if (!rst_ni) begin
      phase_q = PH_ENTRY;
      verdict_q.delete();
      n_pend = 0;
    end else begin
      if (tok_i.valid && tok_i.ready) begin
        verdict_q.push_back(grade_token(tok_i.token_kind, tok_i.text_is_number,
                                        tok_i.text_is_string_keyword, tok_i.last_token));
      end
      if (res_i.valid && res_i.ready) begin
        got = '{res_i.out_tag, res_i.check_status, res_i.expected_kind, res_i.is_last};
        n_chk++;
        if (got.status != ST_OK) n_flag++;
        if (verdict_q.size() == 0) begin
          note_miss("unexpected result", '0, got);
        end else begin
          want = verdict_q.pop_front();
          if (want !== got) note_miss("result mismatch", want, got);
        end
      end
      n_pend = verdict_q.size();
    end
  end

endmodule

[dv/tb_bibtex_entry_token_checker_core.sv]
module tb_bibtex_entry_token_checker_core;
  import bibchk_pkg::*;

  // Kinds past the defined range; the block folds them onto K_OTHER.
  localparam logic [3:0] KIND_PAST = K_OTHER + 4'd1;
  localparam logic [3:0] KIND_MAX  = 4'hF;

  localparam int TOKEN_TARGET = 500;

  typedef struct packed {
    logic [3:0] kind;
    logic       num;
    logic       kw;
    logic       last;
  } tok_t;

  logic        clk_i;
  logic        rst_ni;
  bit          full_rate;
  tok_t        entry_q[$];
  int unsigned err_cnt, pending, checked, flagged;
  int unsigned n_tok, n_entry, n_string, n_broken;

  bibchk_tok_if tok_if();
  bibchk_res_if res_if();

  bibtex_entry_token_checker_core u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tok_i  (tok_if),
    .res_o  (res_if)
  );

  // Watch both channels, predict every beat and compare in order.
  bibchk_scoreboard u_sb (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .tok_i     (tok_if),
    .res_i     (res_if),
    .err_cnt_o (err_cnt),
    .pending_o (pending),
    .checked_o (checked),
    .flagged_o (flagged)
  );

  initial clk_i = 1'b0;
  always #10 clk_i = ~clk_i;

  // Hard stop in case the block hangs or drops results.
  initial begin
    #5000000;
    $display("DONE: errors detected");
    $finish;
  end

  // Gap length before a token beat: mostly back to back, some short holes,
  // a few long ones. Full-rate stretches disable gaps altogether.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (full_rate || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // Result-side backpressure: alternate runs of ready and stall.
  initial begin
    int run;
    bit rdy;
    run = 0;
    rdy = 1'b0;
    res_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (full_rate) begin
        res_if.ready <= 1'b1;
      end else begin
        if (run == 0) begin
          rdy = ($urandom_range(0, 99) < 65);
          if (rdy) run = $urandom_range(1, 12);
          else if ($urandom_range(0, 9) < 8) run = $urandom_range(1, 2);
          else run = $urandom_range(8, 25);
        end
        run--;
        res_if.ready <= rdy;
      end
    end
  end

  // Drive one token beat. Enter and leave at a falling edge; hold valid
  // high across back-to-back beats so it is never dropped and raised in
  // the same step.
  task automatic push_beat(input tok_t t);
    int gap;
    gap = gap_len();
    if (gap > 0) begin
      tok_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    tok_if.valid                  <= 1'b1;
    tok_if.token_kind             <= t.kind;
    tok_if.text_is_number         <= t.num;
    tok_if.text_is_string_keyword <= t.kw;
    tok_if.last_token             <= t.last;
    do @(posedge clk_i); while (!tok_if.ready);
    n_tok++;
    @(negedge clk_i);
  endtask

  // Hold the sender until every predicted result has come back.
  task automatic drain();
    tok_if.valid <= 1'b0;
    wait (pending == 0);
    @(negedge clk_i);
  endtask

  // Token with don't-care flags randomized so every input bit toggles.
  function automatic tok_t any_tok(input logic [3:0] kind);
    tok_t t;
    t.kind = kind;
    t.num  = 1'($urandom_range(0, 1));
    t.kw   = 1'($urandom_range(0, 1));
    t.last = 1'b0;
    return t;
  endfunction

  function automatic void add(input logic [3:0] kind, input logic num, input logic kw);
    tok_t t;
    t = '{kind, num, kw, 1'b0};
    entry_q.push_back(t);
  endfunction

  function automatic void add_any(input logic [3:0] kind);
    entry_q.push_back(any_tok(kind));
  endfunction

  // Close the entry: flag the final beat as last, then send the whole line.
  task automatic send_entry();
    entry_q[entry_q.size() - 1].last = 1'b1;
    foreach (entry_q[i]) push_beat(entry_q[i]);
    entry_q.delete();
    n_entry++;
  endtask

  // One value: number, bracketed, quoted, number followed by text, or none.
  function automatic void add_value();
    tok_t t;
    int   form;
    form = $urandom_range(0, 4);
    if (form == 0 || form == 3) begin
      t = any_tok(K_TEXT);
      t.num = 1'b1;
      entry_q.push_back(t);
    end
    if (form >= 1 && form <= 3) begin
      add_any($urandom_range(0, 1) ? K_OPEN : K_QUOTE);
      add_any(K_TEXT);
      add_any($urandom_range(0, 1) ? K_CLOSE : K_QUOTE);
    end
  endfunction

  function automatic void build_regular();
    int npairs;
    int tail;
    add(K_ENTRY, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    add(K_TEXT, 1'($urandom_range(0, 1)), 1'b0);
    add_any(K_OPEN);
    add_any(K_TEXT);
    add_any(K_COMMA);
    npairs = $urandom_range(1, 4);
    for (int i = 0; i < npairs; i++) begin
      add_any(K_TEXT);
      add_any(K_EQUAL);
      add_value();
      if (i < npairs - 1) add_any(K_COMMA);
      else add_any($urandom_range(0, 3) == 0 ? K_COMMA : K_CLOSE);
    end
    tail = $urandom_range(0, 3);
    if (tail >= 1) add_any(K_EOF);
    if (tail == 3) begin
      repeat ($urandom_range(1, 3)) add_any(4'($urandom_range(0, 15)));
    end
  endfunction

  function automatic void build_string();
    add(K_ENTRY, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    add(K_TEXT, 1'($urandom_range(0, 1)), 1'b1);
    add_any(K_OPEN);
    add_any(K_TEXT);
    add_any(K_EQUAL);
    add_any(K_TEXT);
    add_any(K_CLOSE);
    add_any(K_CLOSE);
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 2)) add_any(4'($urandom_range(0, 15)));
    end
  endfunction

  // Break a well-formed line: swap a kind, flip a text flag, or cut it short.
  function automatic void corrupt_entry();
    int idx;
    idx = $urandom_range(0, entry_q.size() - 1);
    case ($urandom_range(0, 3))
      0: entry_q[idx].kind = 4'($urandom_range(0, 15));
      1: entry_q[idx].num  = ~entry_q[idx].num;
      2: entry_q[idx].kw   = ~entry_q[idx].kw;
      default: begin
        while (entry_q.size() > idx + 1) void'(entry_q.pop_back());
      end
    endcase
  endfunction

  initial begin
    int pick;
    tok_if.valid                  = 1'b0;
    tok_if.token_kind             = K_ENTRY;
    tok_if.text_is_number         = 1'b0;
    tok_if.text_is_string_keyword = 1'b0;
    tok_if.last_token             = 1'b0;
    full_rate = 1'b0;
    n_tok     = 0;
    n_entry   = 0;
    n_string  = 0;
    n_broken  = 0;
    rst_ni    = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: a regular entry with a number-then-quoted value, a missing
    // value checked as its separator, end of file after a pair and an
    // out-of-range kind as the last beat.
    add(K_ENTRY, 1'b0, 1'b0);
    add(K_TEXT, 1'b0, 1'b0);
    add(K_OPEN, 1'b0, 1'b0);
    add(K_TEXT, 1'b1, 1'b1);
    add(K_COMMA, 1'b0, 1'b0);
    add(K_TEXT, 1'b0, 1'b0);
    add(K_EQUAL, 1'b0, 1'b0);
    add(K_TEXT, 1'b1, 1'b0);
    add(K_QUOTE, 1'b0, 1'b0);
    add(K_TEXT, 1'b0, 1'b1);
    add(K_QUOTE, 1'b0, 1'b0);
    add(K_COMMA, 1'b0, 1'b0);
    add(K_TEXT, 1'b0, 1'b0);
    add(K_EQUAL, 1'b0, 1'b0);
    add(K_CLOSE, 1'b0, 1'b0);
    add(K_EOF, 1'b0, 1'b0);
    add(KIND_MAX, 1'b1, 1'b1);
    send_entry();
    // Directed: a string entry run to its second close bracket.
    add(K_ENTRY, 1'b0, 1'b0);
    add(K_TEXT, 1'b0, 1'b1);
    add(K_OPEN, 1'b0, 1'b0);
    add(K_TEXT, 1'b0, 1'b0);
    add(K_EQUAL, 1'b0, 1'b0);
    add(K_TEXT, 1'b1, 1'b0);
    add(K_CLOSE, 1'b0, 1'b0);
    add(K_CLOSE, 1'b0, 1'b0);
    send_entry();
    n_string++;
    // Directed: a lone out-of-range kind where the entry marker belongs.
    add(KIND_PAST, 1'b1, 1'b0);
    send_entry();
    n_broken++;
    drain();

    // Random: mostly well-formed entries, some broken ones, some noise.
    while (n_tok < TOKEN_TARGET) begin
      full_rate = ($urandom_range(0, 9) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        build_regular();
      end else if (pick < 80) begin
        build_string();
        n_string++;
      end else begin
        repeat ($urandom_range(1, 6)) add_any(4'($urandom_range(0, 15)));
        n_broken++;
      end
      if (pick < 80 && $urandom_range(0, 99) < 30) begin
        corrupt_entry();
        n_broken++;
      end
      send_entry();
      if (n_entry % 40 == 0) drain();
    end
    full_rate = 1'b0;
    tok_if.valid <= 1'b0;

    // Let the pipeline empty, then a few more edges for stray beats.
    wait (pending == 0);
    repeat (8) @(posedge clk_i);

    $display("Sent %0d tokens in %0d entries: %0d string-type, %0d broken or noise.",
             n_tok, n_entry, n_string, n_broken);
    $display("Checked %0d results, %0d of them flagged wrong, number or skipped.",
             checked, flagged);
    if (err_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[filelist.f]
src/bibchk_pkg.sv
src/bibchk_if.sv
src/bibtex_entry_token_checker_core.sv
dv/bibchk_scoreboard.sv
dv/tb_bibtex_entry_token_checker_core.sv
